>>> rtl/ade_pkg.sv
package ade_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 20;
    localparam int LIMIT_W       = 24;
    localparam int MODE_W        = 2;
    localparam int CNT_W         = 32;
    localparam int COFFEE_W      = 4;
    localparam int COFFEE_EVENTS = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    // Axis difference is one bit wider than a sample; compare at the wider of the two
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

    // Stream packing: input x | y | z | door, result fired | total | advertise
    localparam int S_X_LO      = 0;
    localparam int S_Y_LO      = SAMPLE_BITS;
    localparam int S_Z_LO      = 2 * SAMPLE_BITS;
    localparam int S_DOOR_BIT  = 3 * SAMPLE_BITS;
    localparam int S_FIELDS_W  = 3 * SAMPLE_BITS + 1;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIRED_BIT = 0;
    localparam int M_TOTAL_LO  = 1;
    localparam int M_ADV_BIT   = CNT_W + 1;
    localparam int M_FIELDS_W  = CNT_W + 2;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LIMIT_W-1:0]            limit_t;
    typedef logic [MODE_W-1:0]             mode_t;
    typedef logic [COFFEE_W-1:0]           coffee_t;
    typedef logic [CNT_W-1:0]              count_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 2'd0,
        REG_LIMIT_X = 2'd1,
        REG_LIMIT_Y = 2'd2,
        REG_LIMIT_Z = 2'd3
    } reg_idx_t;

    // Operating modes; any code other than door or coffee acts as chair
    localparam mode_t MODE_CHAIR  = 2'd1;
    localparam mode_t MODE_DOOR   = 2'd2;
    localparam mode_t MODE_COFFEE = 2'd3;

    localparam limit_t  LIMIT_RESET = 24'd128;
    localparam coffee_t COFFEE_LAST = COFFEE_W'(COFFEE_EVENTS);

    typedef struct packed {
        mode_t  mode;
        limit_t limit_x;
        limit_t limit_y;
        limit_t limit_z;
    } cfg_t;

endpackage

>>> rtl/ade_regs.sv
module ade_regs
    import ade_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Register file, to be written only while the datapath is idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode    <= MODE_CHAIR;
            cfg_reg.limit_x <= LIMIT_RESET;
            cfg_reg.limit_y <= LIMIT_RESET;
            cfg_reg.limit_z <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:    cfg_reg.mode    <= cfg_data[MODE_W-1:0];
                REG_LIMIT_X: cfg_reg.limit_x <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_Y: cfg_reg.limit_y <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_Z: cfg_reg.limit_z <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ade_axis.sv
module ade_axis
    import ade_pkg::*;
(
    input  sample_t sample,
    input  sample_t ref_val,
    input  limit_t  limit,
    output logic    moved
);

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;

    // Exact difference, then magnitude; strictly greater than the limit is a move
    assign diff  = {sample[SAMPLE_BITS-1], sample} - {ref_val[SAMPLE_BITS-1], ref_val};
    assign mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign moved = CMP_W'(mag) > CMP_W'(limit);

endmodule

>>> rtl/accel_delta_event_detector.sv
// Send-on-delta event detector for a three-axis accelerometer.
// Input stream (s_*): one transaction per sample, tdata carries accel_x,
// accel_y, accel_z (signed) and the door-open level. Result stream (m_*):
// one transaction per sample with event_fired, event_total and advertise.
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge (0 mode_select, 1..3 axis limits); write only while idle.
// Path: an accepted sample is registered, evaluated against the reference
// and gate state, and loaded into the result register, which drives m_tvalid.
// Throughput: one sample per cycle while the receiver does not stall; the input
// register and the result register form a two-stage path, and state is updated
// in the same cycle the result register loads.
// Receiver stall: the result holds in its register; one more sample waits
// in the input register, after which s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous): both stages empty, no reference, all
// counters zero, mode chair, limits 128. The first sample after reset only
// becomes the reference and yields a result with event_fired 0.
module accel_delta_event_detector
    import ade_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // accel_x, accel_y, accel_z, door_is_open, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // event_fired, event_total, advertise, zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic    in_valid_reg;
    sample_t in_x_reg, in_y_reg, in_z_reg;
    logic    in_door_reg;

    sample_t ref_x_reg, ref_y_reg, ref_z_reg;
    logic    have_ref_reg;
    count_t  event_cnt_reg, event_cnt_next;
    coffee_t coffee_reg, coffee_next;
    logic    pair_reg, pair_next;

    logic    out_valid_reg;
    logic    out_fired_reg;
    count_t  out_total_reg;
    logic    out_adv_reg;

    logic    advance;
    logic    moved_x, moved_y, moved_z;
    logic    fire, adv;

    ade_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ade_axis u_axis_x (.sample(in_x_reg), .ref_val(ref_x_reg), .limit(cfg.limit_x), .moved(moved_x));
    ade_axis u_axis_y (.sample(in_y_reg), .ref_val(ref_y_reg), .limit(cfg.limit_y), .moved(moved_y));
    ade_axis u_axis_z (.sample(in_z_reg), .ref_val(ref_z_reg), .limit(cfg.limit_z), .moved(moved_z));

    // Handshake: evaluate when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_x_reg    <= s_tdata[S_X_LO +: SAMPLE_BITS];
            in_y_reg    <= s_tdata[S_Y_LO +: SAMPLE_BITS];
            in_z_reg    <= s_tdata[S_Z_LO +: SAMPLE_BITS];
            in_door_reg <= s_tdata[S_DOOR_BIT];
        end
    end

    // Event decision and send gate
    always_comb begin
        fire           = have_ref_reg &&
                         ((cfg.mode == MODE_DOOR && in_door_reg) || moved_x || moved_y || moved_z);
        adv            = 1'b0;
        event_cnt_next = event_cnt_reg;
        coffee_next    = coffee_reg;
        pair_next      = pair_reg;
        if (fire) begin
            event_cnt_next = event_cnt_reg + 1'b1;
            if (cfg.mode == MODE_COFFEE && coffee_reg < COFFEE_LAST) begin
                coffee_next = coffee_reg + 1'b1;
            end else if (!pair_reg) begin
                pair_next = 1'b1;
            end else begin
                pair_next   = 1'b0;
                coffee_next = '0;
                adv         = 1'b1;
            end
        end
    end

    // Reference and gate state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_ref_reg  <= 1'b0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            ref_z_reg     <= '0;
            event_cnt_reg <= '0;
            coffee_reg    <= '0;
            pair_reg      <= 1'b0;
        end else if (advance) begin
            have_ref_reg  <= 1'b1;
            event_cnt_reg <= event_cnt_next;
            coffee_reg    <= coffee_next;
            pair_reg      <= pair_next;
            if (fire || !have_ref_reg) begin
                ref_x_reg <= in_x_reg;
                ref_y_reg <= in_y_reg;
                ref_z_reg <= in_z_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_fired_reg <= fire;
            out_total_reg <= event_cnt_next;
            out_adv_reg   <= adv;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata                          = '0;
        m_tdata[M_FIRED_BIT]             = out_fired_reg;
        m_tdata[M_TOTAL_LO +: CNT_W]     = out_total_reg;
        m_tdata[M_ADV_BIT]               = out_adv_reg;
    end

endmodule

>>> rtl/ade_checker.sv
module ade_checker
    import ade_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    count_t last_total_reg;
    logic   out_acc;
    logic   fired;
    count_t total;

    assign out_acc = m_tvalid && m_tready;
    assign fired   = m_tdata[M_FIRED_BIT];
    assign total   = m_tdata[M_TOTAL_LO +: CNT_W];

    // Count seen in the last delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_total_reg <= '0;
        end else if (out_acc) begin
            last_total_reg <= total;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Advertise only comes with an event
    a_adv_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_ADV_BIT] |-> fired)
        else $error("advertise without event");

    // Count steps by one on each event and holds otherwise
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> total == last_total_reg + CNT_W'(fired))
        else $error("event count out of step");

    // Input back-pressure only while the result side is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

bind accel_delta_event_detector ade_checker u_ade_checker (.*);
